// ===== hdl/timestamp_delay_mirror_buffer_macros.svh =====
// Assertion macros for the delay mirror buffer.
`ifndef TIMESTAMP_DELAY_MIRROR_BUFFER_MACROS_SVH
`define TIMESTAMP_DELAY_MIRROR_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
`define TDMB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TDMB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDMB_ASSERT(lbl, clk, rst, prop, msg)
`define TDMB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/tdmb_pkg.sv =====
package tdmb_pkg;

  localparam int BUFFER_DEPTH = 512;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int SLOT_W       = 9;
  localparam int TS_W         = 32;
  localparam int QUAT_W       = 64;
  localparam int ROW_W        = 4 * QUAT_W;
  localparam int DELAY_W      = 16;
  localparam int MODE_W       = 2;
  localparam int ARM_W        = 2;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

  localparam logic [MODE_W-1:0] MODE_L2R  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_R2L  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

  localparam logic [ARM_W-1:0] ARM_RIGHT = 2'd0;
  localparam logic [ARM_W-1:0] ARM_LEFT  = 2'd1;
  localparam logic [ARM_W-1:0] ARM_NONE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 4'd1;

  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [ADDR_W-1:0] index;
  } scan_ctl_t;

endpackage

// ===== hdl/tdmb_channels.sv =====
interface tdmb_frame_if import tdmb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   timestamp_ms;
  logic [QUAT_W-1:0] left_joint2_quat;
  logic [QUAT_W-1:0] left_joint3_quat;
  logic [QUAT_W-1:0] right_joint2_quat;
  logic [QUAT_W-1:0] right_joint3_quat;

  modport source (
    output valid, timestamp_ms, left_joint2_quat, left_joint3_quat,
           right_joint2_quat, right_joint3_quat,
    input  ready
  );
  modport sink (
    input  valid, timestamp_ms, left_joint2_quat, left_joint3_quat,
           right_joint2_quat, right_joint3_quat,
    output ready
  );
endinterface

interface tdmb_result_if import tdmb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ARM_W-1:0]  target_arm;
  logic [QUAT_W-1:0] mirrored_joint2_quat;
  logic [QUAT_W-1:0] mirrored_joint3_quat;
  logic              delayed_used;
  logic [SLOT_W-1:0] chosen_slot;

  modport source (
    output valid, target_arm, mirrored_joint2_quat, mirrored_joint3_quat,
           delayed_used, chosen_slot,
    input  ready
  );
  modport sink (
    input  valid, target_arm, mirrored_joint2_quat, mirrored_joint3_quat,
           delayed_used, chosen_slot,
    output ready
  );
endinterface

// ===== hdl/timestamp_delay_mirror_buffer.sv =====
// Channel  | Role   | Payload
// frame    | sink   | timestamp_ms, left/right joint 2/3 quaternions
// result   | source | target_arm, mirrored joint 2/3, delayed_used, chosen_slot
//
// Delayed frame: a sweep of the 512-entry timestamp memory, one read per cycle,
// then select and quat read. Undelayed frame: select and quat read only.
// A new frame is accepted only once the last result is loaded for output.
// Reset starts a clearing pass of both memories; frames wait, config not.
// A result held by a stalled sink stays in the output register while the next
// frame is accepted and processed; that frame waits for the register to free.
`include "timestamp_delay_mirror_buffer_macros.svh"

module timestamp_delay_mirror_buffer import tdmb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tdmb_frame_if.sink            frame,
  tdmb_result_if.source         result
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SEL   = 3'd4;
  localparam logic [2:0] ST_QRD   = 3'd5;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(BUFFER_DEPTH - 1);

  logic [2:0]         state;
  logic [ADDR_W-1:0]  cnt;
  logic [ADDR_W-1:0]  wp;
  logic [ADDR_W-1:0]  cur_slot;
  logic [DELAY_W-1:0] delay_ms;
  logic [MODE_W-1:0]  mirror_mode;
  logic [TS_W-1:0]    target;
  logic               delayed;
  logic               scan_vld;
  logic [ADDR_W-1:0]  scan_idx;

  logic               accept;
  logic               clearing;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [TS_W-1:0]    time_wdata;
  logic [ROW_W-1:0]   row_wdata;
  logic [TS_W-1:0]    time_rdata;
  logic [ROW_W-1:0]   row_rdata;
  logic [ADDR_W-1:0]  best_idx;
  logic [ADDR_W-1:0]  chosen;
  logic               delay_hit;
  logic               load_out;
  scan_ctl_t          scan_ctl;
  logic [ARM_W-1:0]   m_arm;
  logic [QUAT_W-1:0]  m_q2;
  logic [QUAT_W-1:0]  m_q3;

  assign frame.ready = (state == ST_IDLE);
  assign accept      = frame.valid && frame.ready;
  assign clearing    = (state == ST_CLEAR);
  assign mem_we      = clearing || accept;
  assign mem_waddr   = clearing ? cnt : wp;
  assign time_wdata  = clearing ? '0 : frame.timestamp_ms;
  assign row_wdata   = clearing ? '0 : {frame.left_joint2_quat, frame.left_joint3_quat,
                                        frame.right_joint2_quat, frame.right_joint3_quat};
  assign chosen      = delayed ? best_idx : cur_slot;
  assign delay_hit   = (delay_ms != '0) && (frame.timestamp_ms >= TS_W'(delay_ms));
  assign load_out    = (state == ST_QRD) && (!result.valid || result.ready);

  assign scan_ctl.clear = accept;
  assign scan_ctl.valid = scan_vld;
  assign scan_ctl.index = scan_idx;

  tdmb_ram #(.WIDTH(TS_W), .DEPTH(BUFFER_DEPTH)) u_time_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (time_wdata),
    .raddr (cnt),
    .rdata (time_rdata)
  );

  tdmb_ram #(.WIDTH(ROW_W), .DEPTH(BUFFER_DEPTH)) u_quat_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (row_wdata),
    .raddr (chosen),
    .rdata (row_rdata)
  );

  tdmb_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .time_data (time_rdata),
    .target    (target),
    .best_idx  (best_idx)
  );

  tdmb_mirror u_mirror (
    .mode (mirror_mode),
    .row  (row_rdata),
    .arm  (m_arm),
    .q2   (m_q2),
    .q3   (m_q3)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms    <= DELAY_RESET;
      mirror_mode <= MODE_L2R;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY: delay_ms    <= cfg_data[DELAY_W-1:0];
        REG_MODE:  mirror_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      wp       <= '0;
      delayed  <= 1'b0;
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= (state == ST_SCAN);
      unique case (state)
        ST_CLEAR: begin
          cnt <= (cnt == LAST_SLOT) ? '0 : cnt + 1'b1;
          if (cnt == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cnt     <= '0;
            wp      <= (wp == LAST_SLOT) ? '0 : wp + 1'b1;
            delayed <= delay_hit;
            state   <= delay_hit ? ST_SCAN : ST_SEL;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_SLOT) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_SEL;
        ST_SEL:   state <= ST_QRD;
        ST_QRD: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= cnt;
    if (accept) begin
      cur_slot <= wp;
      target   <= frame.timestamp_ms - TS_W'(delay_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.target_arm           <= m_arm;
      result.mirrored_joint2_quat <= m_q2;
      result.mirrored_joint3_quat <= m_q3;
      result.delayed_used         <= delayed;
      result.chosen_slot          <= SLOT_W'(chosen);
    end
  end

  `TDMB_ASSERT(a_accept_next, clk, rst, accept |=> (state == ST_SCAN || state == ST_SEL), "accepted frame did not start processing")
  `TDMB_ASSERT(a_sel_source, clk, rst, (state == ST_SEL) |-> (($past(state) == ST_DRAIN) == delayed), "slot selection out of step with the sweep")
  `TDMB_ASSERT_ALWAYS(a_no_accept_clear, clk, clearing |-> !accept, "frame accepted during clearing pass")

endmodule

// ===== hdl/tdmb_ram.sv =====
module tdmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tdmb_mirror.sv =====
module tdmb_mirror import tdmb_pkg::*; (
  input  logic [MODE_W-1:0] mode,
  input  logic [ROW_W-1:0]  row,
  output logic [ARM_W-1:0]  arm,
  output logic [QUAT_W-1:0] q2,
  output logic [QUAT_W-1:0] q3
);

  function automatic logic [15:0] neg_comp(input logic [15:0] v);
    if (v == 16'h8000) begin
      return 16'h7FFF;
    end
    return 16'(~v + 16'd1);
  endfunction

  function automatic logic [QUAT_W-1:0] mirror_quat(input logic [QUAT_W-1:0] q);
    return {q[63:32], neg_comp(q[31:16]), neg_comp(q[15:0])};
  endfunction

  // row: left j2, left j3, right j2, right j3 from the top down
  always_comb begin
    unique case (mode)
      MODE_L2R: begin
        arm = ARM_RIGHT;
        q2  = mirror_quat(row[ROW_W-1 -: QUAT_W]);
        q3  = mirror_quat(row[ROW_W-QUAT_W-1 -: QUAT_W]);
      end
      MODE_R2L: begin
        arm = ARM_LEFT;
        q2  = mirror_quat(row[2*QUAT_W-1 -: QUAT_W]);
        q3  = mirror_quat(row[QUAT_W-1:0]);
      end
      default: begin
        arm = ARM_NONE;
        q2  = '0;
        q3  = '0;
      end
    endcase
  end

endmodule

// ===== hdl/tdmb_scan.sv =====
module tdmb_scan import tdmb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  logic [TS_W-1:0]   time_data,
  input  logic [TS_W-1:0]   target,
  output logic [ADDR_W-1:0] best_idx
);

  logic            have;
  logic [TS_W-1:0] best_dist;
  logic [TS_W-1:0] delta;

  assign delta = (time_data > target) ? (time_data - target) : (target - time_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clear) begin
      have <= 1'b0;
    end else if (ctl.valid) begin
      have <= 1'b1;
    end
  end

  // ascending sweep, <= keeps the highest slot on a tie
  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.valid && (!have || delta <= best_dist)) begin
      best_dist <= delta;
      best_idx  <= ctl.index;
    end
  end

endmodule

// ===== tb/tb_timestamp_delay_mirror_buffer.sv =====
`default_nettype none

module tb_timestamp_delay_mirror_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import tdmb_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CHUNK_ITEMS   = 35;
  localparam longint LIMIT_NS  = 30_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 4'd9;
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [15:0]          NEG_MIN    = 16'h8000;
  localparam logic [15:0]          POS_MAX    = 16'h7FFF;

  typedef struct packed {
    logic [TS_W-1:0]   ts;
    logic [QUAT_W-1:0] lj2;
    logic [QUAT_W-1:0] lj3;
    logic [QUAT_W-1:0] rj2;
    logic [QUAT_W-1:0] rj3;
  } frame_t;

  typedef struct packed {
    logic [ARM_W-1:0]  arm;
    logic [QUAT_W-1:0] j2;
    logic [QUAT_W-1:0] j3;
    logic              delayed;
    logic [SLOT_W-1:0] slot;
  } mirror_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  hold_ready = 1'b0;

  tdmb_frame_if  frame_bus ();
  tdmb_result_if result_bus ();

  timestamp_delay_mirror_buffer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_bus),
    .result    (result_bus)
  );

  // shadow of the ring buffer and registers
  logic [TS_W-1:0]    shadow_times [BUFFER_DEPTH];
  logic [QUAT_W-1:0]  shadow_quats [BUFFER_DEPTH][4];
  int unsigned        shadow_wp;
  logic [DELAY_W-1:0] delay_now;
  logic [MODE_W-1:0]  mode_now;

  mirror_t     mirror_queue [$];
  int          mismatch_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] clock_ms = 32'd5000;
  logic [31:0] last_ts = '0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [15:0] negate_sat(logic [15:0] c);
    return (c == NEG_MIN) ? POS_MAX : (~c + 16'd1);
  endfunction

  function automatic logic [QUAT_W-1:0] flip_quat(logic [QUAT_W-1:0] q);
    return {q[63:32], negate_sat(q[31:16]), negate_sat(q[15:0])};
  endfunction

  function automatic mirror_t predict_mirror(frame_t f);
    mirror_t         m;
    int unsigned     wr;
    int unsigned     slot;
    int              i;
    logic [TS_W-1:0] goal;
    logic [TS_W-1:0] delta;
    logic [TS_W-1:0] best;
    bit              found;
    wr = shadow_wp;
    shadow_times[wr]    = f.ts;
    shadow_quats[wr][0] = f.lj2;
    shadow_quats[wr][1] = f.lj3;
    shadow_quats[wr][2] = f.rj2;
    shadow_quats[wr][3] = f.rj3;
    shadow_wp = (wr + 1) % BUFFER_DEPTH;
    slot = wr;
    m.delayed = 1'b0;
    best = '0;
    found = 1'b0;
    if (delay_now != '0 && f.ts >= TS_W'(delay_now)) begin
      goal = f.ts - TS_W'(delay_now);
      m.delayed = 1'b1;
      for (i = BUFFER_DEPTH - 1; i >= 0; i--) begin
        delta = (shadow_times[i] > goal) ? shadow_times[i] - goal : goal - shadow_times[i];
        // strict compare on a descending sweep: highest slot wins a tie
        if (!found || delta < best) begin
          best  = delta;
          slot  = i;
          found = 1'b1;
        end
      end
    end
    case (mode_now)
      MODE_L2R: begin
        m.arm = ARM_RIGHT;
        m.j2  = flip_quat(shadow_quats[slot][0]);
        m.j3  = flip_quat(shadow_quats[slot][1]);
      end
      MODE_R2L: begin
        m.arm = ARM_LEFT;
        m.j2  = flip_quat(shadow_quats[slot][2]);
        m.j3  = flip_quat(shadow_quats[slot][3]);
      end
      default: begin
        m.arm = ARM_NONE;
        m.j2  = '0;
        m.j3  = '0;
      end
    endcase
    m.slot = SLOT_W'(slot);
    return m;
  endfunction

  function automatic frame_t make_frame(logic [TS_W-1:0] ts, logic [QUAT_W-1:0] lj2,
                                        logic [QUAT_W-1:0] lj3, logic [QUAT_W-1:0] rj2,
                                        logic [QUAT_W-1:0] rj3);
    frame_t f;
    f.ts  = ts;
    f.lj2 = lj2;
    f.lj3 = lj3;
    f.rj2 = rj2;
    f.rj3 = rj3;
    return f;
  endfunction

  function automatic logic [QUAT_W-1:0] rand_quat();
    logic [QUAT_W-1:0] q;
    q = {$urandom, $urandom};
    if ($urandom_range(9) == 0) q[31:16] = NEG_MIN;
    if ($urandom_range(9) == 0) q[15:0] = NEG_MIN;
    return q;
  endfunction

  // mostly a steady ~30 Hz clock, with repeats and wild timestamps mixed in
  function automatic frame_t rand_frame();
    logic [TS_W-1:0] ts;
    clock_ms = clock_ms + $urandom_range(20, 45);
    case ($urandom_range(19))
      0:       ts = $urandom;
      1:       ts = last_ts;
      default: ts = clock_ms;
    endcase
    last_ts = ts;
    return make_frame(ts, rand_quat(), rand_quat(), rand_quat(), rand_quat());
  endfunction

  function automatic logic [DELAY_W-1:0] rand_delay();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return DELAY_W'($urandom_range(65535));
      default: return DELAY_W'($urandom_range(30, 3000));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DELAY) delay_now = data[DELAY_W-1:0];
    else if (idx == REG_MODE) mode_now = data[MODE_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_frame(frame_t f);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_bus.valid             <= 1'b1;
    frame_bus.timestamp_ms      <= f.ts;
    frame_bus.left_joint2_quat  <= f.lj2;
    frame_bus.left_joint3_quat  <= f.lj3;
    frame_bus.right_joint2_quat <= f.rj2;
    frame_bus.right_joint3_quat <= f.rj3;
    do @(posedge clk); while (!frame_bus.ready);
    mirror_queue.push_back(predict_mirror(f));
  endtask

  task automatic drain();
    frame_bus.valid <= 1'b0;
    while (mirror_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [QUAT_W-1:0] want, logic [QUAT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) result_bus.ready <= 1'b0;
    else result_bus.ready <= !hold_ready && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_result
    mirror_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (mirror_queue.size() == 0) begin
        $error("result transaction with no frame outstanding");
        mismatch_count++;
      end else begin
        want = mirror_queue.pop_front();
        check_field("target_arm", QUAT_W'(want.arm), QUAT_W'(result_bus.target_arm));
        check_field("mirrored_joint2_quat", want.j2, result_bus.mirrored_joint2_quat);
        check_field("mirrored_joint3_quat", want.j3, result_bus.mirrored_joint3_quat);
        check_field("delayed_used", QUAT_W'(want.delayed), QUAT_W'(result_bus.delayed_used));
        check_field("chosen_slot", QUAT_W'(want.slot), QUAT_W'(result_bus.chosen_slot));
      end
    end
  end

  // defaults: delay 1000, left drives right; the empty store ties at zero
  task automatic test_reset_defaults();
    send_frame(make_frame(32'd999, 64'h4000_0100_0200_0300, 64'h3FFF_C000_8000_0001,
                          64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888));
    send_frame(make_frame(32'd1000, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                          64'hA5A5_5A5A_8000_8000, 64'h0F0F_F0F0_7FFF_FFFF));
    send_frame(make_frame(32'd0, '1, '0, '0, '1));
    drain();
  endtask

  task automatic test_field_extremes();
    write_reg(REG_DELAY, '0);
    send_frame(make_frame('1, '1, '1, '1, '1));
    send_frame(make_frame('0, '0, '0, '0, '0));
    send_frame(make_frame(32'h8000_0000, {4{NEG_MIN}}, {4{POS_MAX}},
                          {4{POS_MAX}}, {4{NEG_MIN}}));
    drain();
    write_reg(REG_DELAY, '1);
    send_frame(make_frame(32'd65534, 64'h7FFF_8000_0001_FFFF, 64'h8000_7FFF_FFFF_0001,
                          64'h0001_0002_8000_7FFE, 64'hFFFE_0003_0004_8000));
    send_frame(make_frame(32'd65535, 64'h1234_5678_9ABC_DEF0, 64'h0FED_CBA9_8765_4321,
                          64'h2468_ACE0_1357_9BDF, 64'hFDB9_7531_ECA8_6420));
    send_frame(make_frame('1, 64'h5A5A_A5A5_0000_8000, 64'hC3C3_3C3C_8000_0000,
                          64'hDEAD_BEEF_CAFE_F00D, 64'hFACE_B00C_0BAD_F00D));
    drain();
  endtask

  task automatic test_distance_tie();
    write_reg(REG_DELAY, 16'd60);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_R2L));
    // 1100 then 1000, target 1050: equal distance, later slot must win
    send_frame(make_frame(32'd1100, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    send_frame(make_frame(32'd1000, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    send_frame(make_frame(32'd1110, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    // exact match held in two slots
    send_frame(make_frame(32'd2000, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    send_frame(make_frame(32'd2000, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    send_frame(make_frame(32'd2060, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    drain();
  endtask

  task automatic test_mirror_modes();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_NONE));
    send_frame(make_frame(32'd2100, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    drain();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
    send_frame(make_frame(32'd2130, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    drain();
    // upper data bits ignored for the mode register
    write_reg(REG_MODE, 16'hFFFC);
    send_frame(make_frame(32'd2160, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    drain();
    write_reg(REG_SPARE, '1);
    send_frame(make_frame(32'd2190, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    drain();
    write_reg(REG_MODE, CFG_DATA_W'(MODE_R2L));
    write_reg(REG_DELAY, 16'd1);
    send_frame(make_frame(32'd2200, rand_quat(), rand_quat(), rand_quat(), rand_quat()));
    drain();
  endtask

  task automatic test_random_traffic(int items, int idle, int stall);
    int sent;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      write_reg(REG_DELAY, rand_delay());
      write_reg(REG_MODE, CFG_DATA_W'($urandom_range(3)));
      repeat (CHUNK_ITEMS) begin
        if (sent < items) begin
          send_frame(rand_frame());
          sent++;
        end
      end
      drain();
    end
  endtask

  // sink held off for a long stretch while frames keep coming
  task automatic test_back_pressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(REG_DELAY, '0);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_L2R));
    fork
      begin
        hold_ready <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ready <= 1'b0;
      end
    join_none
    repeat (12) send_frame(rand_frame());
    drain();
  endtask

  initial begin
    frame_bus.valid             = 1'b0;
    frame_bus.timestamp_ms      = '0;
    frame_bus.left_joint2_quat  = '0;
    frame_bus.left_joint3_quat  = '0;
    frame_bus.right_joint2_quat = '0;
    frame_bus.right_joint3_quat = '0;
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      shadow_times[i] = '0;
      for (int j = 0; j < 4; j++) shadow_quats[i][j] = '0;
    end
    shadow_wp = 0;
    delay_now = DELAY_RESET;
    mode_now  = MODE_L2R;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_distance_tie();
    test_mirror_modes();
    test_random_traffic(140, 0, 0);
    test_random_traffic(130, 80, 0);
    test_random_traffic(130, 0, 80);
    test_random_traffic(150, 21, 21);
    test_back_pressure();

    if (mismatch_count == 0) begin
      $display("timestamp_delay_mirror_buffer verification clean");
    end else begin
      $display("timestamp_delay_mirror_buffer verification failed");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("timestamp_delay_mirror_buffer verification failed");
    $finish;
  end

endmodule

`default_nettype wire
